### rtl/u8sd_pkg.sv
`default_nettype none
package u8sd_pkg;

	localparam int MaxSeqLenDefault = 6;

	// result kind carried in the master tuser
	typedef enum logic [1:0] {
		ST_CHAR       = 2'd0,
		ST_END        = 2'd1,
		ST_INCOMPLETE = 2'd2,
		ST_INVALID    = 2'd3
	} status_t;

	typedef struct packed {
		logic [30:0] unit;
		status_t     status;
		logic        last;
	} result_t;

	// sequence length announced by a lead byte, zero for a stray byte
	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] len;
		len = 3'd0;
		unique case (b) inside
			[8'h00:8'h7f]: len = 3'd1;
			[8'h80:8'hbf]: len = 3'd0;
			[8'hc0:8'hdf]: len = 3'd2;
			[8'he0:8'hef]: len = 3'd3;
			[8'hf0:8'hf7]: len = 3'd4;
			[8'hf8:8'hfb]: len = 3'd5;
			[8'hfc:8'hfd]: len = 3'd6;
			default:       len = 3'd0;
		endcase
		return len;
	endfunction

	// payload bits of a lead byte
	function automatic logic [6:0] lead_payload(input logic [7:0] b);
		logic [6:0] p;
		p = 7'd0;
		unique case (b) inside
			[8'h00:8'h7f]: p = b[6:0];
			[8'hc0:8'hdf]: p = {2'b00, b[4:0]};
			[8'he0:8'hef]: p = {3'b000, b[3:0]};
			[8'hf0:8'hf7]: p = {4'b0000, b[2:0]};
			[8'hf8:8'hfb]: p = {5'b00000, b[1:0]};
			[8'hfc:8'hfd]: p = {6'b000000, b[0]};
			default:       p = 7'd0;
		endcase
		return p;
	endfunction

endpackage
`default_nettype wire

### rtl/utf8_stream_decoder.sv
`default_nettype none
// channel   dir  tdata                       tuser          tlast
// s_axis    in   [7:0] byte_req              [0] action     -
// m_axis    out  [30:0] unit, [31] zero pad  [1:0] status   last
// cfg       in   cfg_wr_data = utf16_output (written when cfg_wr_en is high)
//
// one byte is taken per cycle unless a result must wait for the result register
// the input register feeds the decode logic, which loads a two-slot result register
// a surrogate pair holds the result register for two transactions, so a result
// byte behind it waits for the high surrogate; other bytes give at most one result
// arst_n clears the open sequence, the pipeline valids and the mode register
// m_axis_tready low holds the result register and then the input register
module utf8_stream_decoder #(
	parameter int MAX_SEQ_LEN = u8sd_pkg::MaxSeqLenDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_wr_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // byte_req
	input  wire logic [0:0]  s_axis_tuser,   // action
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // unit, zero pad
	output logic [1:0]       m_axis_tuser,   // status
	output logic             m_axis_tlast    // last
);
	import u8sd_pkg::*;

	localparam logic [2:0] MaxLen = 3'(MAX_SEQ_LEN);

	// mode register
	logic utf16_q;

	// input register
	logic       vld_s1;
	logic       act_s1;
	logic [7:0] byte_s1;

	// decoder state
	logic [2:0]  pend_q;
	logic [30:0] acc_q;

	// result register: slot 0 is presented, slot 1 holds the low surrogate
	result_t    res0_q, res1_q;
	logic [1:0] cnt_q;

	// decode outputs
	result_t     res0_d, res1_d;
	logic [1:0]  nres;
	logic [2:0]  pend_d;
	logic [30:0] acc_d;

	logic out_pop, out_free, advance;

	assign out_pop  = m_axis_tvalid && m_axis_tready;
	assign out_free = (cnt_q == 2'd0) || (cnt_q == 2'd1 && m_axis_tready);
	// bytes that open or extend a sequence give no result and never wait
	assign advance  = vld_s1 && ((nres == 2'd0) || out_free);
	assign s_axis_tready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			utf16_q <= 1'b0;
		end else if (cfg_wr_en) begin
			utf16_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			act_s1  <= s_axis_tuser[0];
			byte_s1 <= s_axis_tdata;
		end
	end

	// completion of a character, with the UTF-16 split
	logic [30:0] cp;
	logic        give;
	logic [19:0] sub;

	assign sub = 20'(cp[20:0] - 21'h10000);

	always_comb begin
		logic [2:0]  len;
		logic [30:0] acc_sh;
		len    = lead_len(byte_s1);
		acc_sh = {acc_q[24:0], byte_s1[5:0]};
		res0_d = '{unit: '0, status: ST_INVALID, last: 1'b1};
		res1_d = '{unit: '0, status: ST_CHAR, last: 1'b1};
		nres   = 2'd1;
		pend_d = pend_q;
		acc_d  = acc_q;
		cp     = '0;
		give   = 1'b0;

		if (act_s1) begin
			// flush: a dangling sequence is invalid
			res0_d.status = (pend_q == 3'd0) ? ST_END : ST_INVALID;
			pend_d = '0;
			acc_d  = '0;
		end else if (byte_s1 == 8'h00) begin
			// terminator leaves an open sequence in place
			res0_d.status = (pend_q == 3'd0) ? ST_END : ST_INCOMPLETE;
		end else if (pend_q != 3'd0) begin
			if (byte_s1[7:6] != 2'b10) begin
				pend_d = '0;
				acc_d  = '0;
			end else if (pend_q == 3'd1) begin
				cp   = acc_sh;
				give = 1'b1;
			end else begin
				pend_d = pend_q - 3'd1;
				acc_d  = acc_sh;
				nres   = 2'd0;
			end
		end else begin
			if (len == 3'd0 || len > MaxLen) begin
				pend_d = '0;
				acc_d  = '0;
			end else if (len == 3'd1) begin
				cp   = {24'd0, byte_s1[6:0]};
				give = 1'b1;
			end else begin
				pend_d = len - 3'd1;
				acc_d  = {24'd0, lead_payload(byte_s1)};
				nres   = 2'd0;
			end
		end

		if (give) begin
			pend_d = '0;
			acc_d  = '0;
			if (!utf16_q || cp[30:16] == 15'd0) begin
				res0_d = '{unit: cp, status: ST_CHAR, last: 1'b1};
			end else if (cp > 31'h10ffff) begin
				res0_d = '{unit: '0, status: ST_INVALID, last: 1'b1};
			end else begin
				// surrogate pair
				res0_d = '{unit: {15'd0, 6'b110110, sub[19:10]}, status: ST_CHAR, last: 1'b0};
				res1_d = '{unit: {15'd0, 6'b110111, sub[9:0]}, status: ST_CHAR, last: 1'b1};
				nres   = 2'd2;
			end
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			acc_q  <= '0;
		end else if (advance) begin
			pend_q <= pend_d;
			acc_q  <= acc_d;
		end
	end

	// result register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (advance && nres != 2'd0) begin
			cnt_q <= nres;
		end else if (out_pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && nres != 2'd0) begin
			res0_q <= res0_d;
			res1_q <= res1_d;
		end else if (out_pop) begin
			res0_q <= res1_q;
		end
	end

	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign m_axis_tdata  = {1'b0, res0_q.unit};
	assign m_axis_tuser  = res0_q.status;
	assign m_axis_tlast  = res0_q.last;

`ifndef ASSERT_OFF
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result register over two entries");

	a_pair_head: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> (!res0_q.last && res0_q.status == ST_CHAR))
		else $error("pair head must be a non-final character unit");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q < MaxLen)
		else $error("pending count beyond sequence limit");

	a_flush_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && act_s1) |=> (pend_q == 3'd0 && acc_q == 31'd0))
		else $error("flush left state behind");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && nres != 2'd0) |-> out_free)
		else $error("result loaded over undelivered data");
`endif

endmodule
`default_nettype wire
